// ----- hw/rtl/mftr_pkg.sv -----
// ----------------------------------------------------------------------------
// mftr_pkg
// Shared types, operation codes and the 5x7 glyph table of the text renderer.
// ----------------------------------------------------------------------------
package mftr_pkg;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_CHAR  = 2'd1;
  localparam logic [1:0] FUNC_RECT  = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  localparam int GLYPH_COLS   = 5;
  localparam int GLYPH_ROWS   = 7;
  localparam int CELL_ADVANCE = 6;
  localparam int GLYPH_COUNT  = 43;
  localparam int EXP_BITS     = 49;

  typedef logic [7:0] glyph_byte_t;
  typedef logic [5:0] glyph_idx_t;

  typedef struct packed {
    logic       valid;
    glyph_idx_t idx;
  } glyph_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic clr;
    logic prep;
    logic rd;
    logic wr;
    logic next_page;
    logic next_col;
    logic emit;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] func;
    logic       draw;
    logic       rd_ok;
    logic       page_end;
    logic       col_end;
    logic       clr_end;
  } dp_status_t;

  localparam glyph_byte_t GLYPH_ROM [GLYPH_COUNT][GLYPH_COLS] = '{
    '{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h42,8'h7F,8'h40,8'h00},
    '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h21,8'h41,8'h45,8'h4B,8'h31},
    '{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
    '{8'h3C,8'h4A,8'h49,8'h49,8'h30}, '{8'h01,8'h71,8'h09,8'h05,8'h03},
    '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h06,8'h49,8'h49,8'h29,8'h1E},
    '{8'h7E,8'h11,8'h11,8'h11,8'h7E}, '{8'h7F,8'h49,8'h49,8'h49,8'h36},
    '{8'h3E,8'h41,8'h41,8'h41,8'h22}, '{8'h7F,8'h41,8'h41,8'h22,8'h1C},
    '{8'h7F,8'h49,8'h49,8'h49,8'h41}, '{8'h7F,8'h09,8'h09,8'h09,8'h01},
    '{8'h3E,8'h41,8'h49,8'h49,8'h7A}, '{8'h7F,8'h08,8'h08,8'h08,8'h7F},
    '{8'h00,8'h41,8'h7F,8'h41,8'h00}, '{8'h20,8'h40,8'h41,8'h3F,8'h01},
    '{8'h7F,8'h08,8'h14,8'h22,8'h41}, '{8'h7F,8'h40,8'h40,8'h40,8'h40},
    '{8'h7F,8'h02,8'h0C,8'h02,8'h7F}, '{8'h7F,8'h04,8'h08,8'h10,8'h7F},
    '{8'h3E,8'h41,8'h41,8'h41,8'h3E}, '{8'h7F,8'h09,8'h09,8'h09,8'h06},
    '{8'h3E,8'h41,8'h51,8'h21,8'h5E}, '{8'h7F,8'h09,8'h19,8'h29,8'h46},
    '{8'h46,8'h49,8'h49,8'h49,8'h31}, '{8'h01,8'h01,8'h7F,8'h01,8'h01},
    '{8'h3F,8'h40,8'h40,8'h40,8'h3F}, '{8'h1F,8'h20,8'h40,8'h20,8'h1F},
    '{8'h3F,8'h40,8'h38,8'h40,8'h3F}, '{8'h63,8'h14,8'h08,8'h14,8'h63},
    '{8'h07,8'h08,8'h70,8'h08,8'h07}, '{8'h61,8'h51,8'h49,8'h45,8'h43},
    '{8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
    '{8'h14,8'h08,8'h3E,8'h08,8'h14}, '{8'h00,8'h41,8'h22,8'h14,8'h08},
    '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
    '{8'h63,8'h13,8'h08,8'h64,8'h63}
  };

  function automatic glyph_sel_t glyph_index(input logic [7:0] code);
    glyph_sel_t s;
    s.valid = 1'b1;
    s.idx   = '0;
    if (code >= 8'h30 && code <= 8'h39) begin
      s.idx = 6'(code - 8'h30);
    end else if (code >= 8'h41 && code <= 8'h5A) begin
      s.idx = 6'(code - 8'h41 + 8'd10);
    end else begin
      case (code)
        8'h3C:   s.idx = 6'd36;
        8'h2B:   s.idx = 6'd37;
        8'h2A:   s.idx = 6'd38;
        8'h3E:   s.idx = 6'd39;
        8'h2E:   s.idx = 6'd40;
        8'h2D:   s.idx = 6'd41;
        8'h25:   s.idx = 6'd42;
        default: s.valid = 1'b0;
      endcase
    end
    return s;
  endfunction

  function automatic glyph_byte_t glyph_column(input glyph_idx_t idx, input logic [2:0] col);
    glyph_byte_t b;
    b = '0;
    if (idx < 6'(GLYPH_COUNT) && col < 3'(GLYPH_COLS)) begin
      b = GLYPH_ROM[idx][col];
    end
    return b;
  endfunction

endpackage

// ----- hw/rtl/mono_framebuffer_text_rect_draw.sv -----
// ----------------------------------------------------------------------------
// mono_framebuffer_text_rect_draw
// Page-organised monochrome frame store with 5x7 text and rectangle drawing.
// ----------------------------------------------------------------------------
// Input channel (in_*): one word per operation: clear, draw character, draw
// rectangle or read byte. Output channel (out_*): exactly one word per input
// word, carrying read_data (reads only) and char_refused (characters only).
// Both channels: a word moves when valid is high and stall is low.
// Drawing is read-modify-write on the single-port frame memory: each column's
// mask is built (S_PREP), then every touched byte is read (S_RD) and written
// back (S_WR), page by page down the bands that the shape spans:
//   read byte: one read, out-of-range read or empty draw: no memory access,
//   character: 5*scale columns, rectangle: its clipped width in columns,
//   clear: zeroes one byte per cycle over the whole memory.
// One operation runs at a time; the next word is taken as soon as the result
// sits in the output register, even while the receiver stalls it. A stalled
// result holds, and a finished operation waits until the register frees.
// After reset the frame memory is zeroed by a pass over all SCREEN_WIDTH*pages
// bytes (1024 at the default size) before the first word is taken; the
// text cursor and the stopped flag reset to zero.
// ----------------------------------------------------------------------------
module mono_framebuffer_text_rect_draw #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [7:0] in_x,
  input  logic [7:0] in_y,
  input  logic [2:0] in_read_page,
  input  logic [7:0] in_width,
  input  logic [7:0] in_height,
  input  logic       in_filled,
  input  logic [7:0] in_char_code,
  input  logic [2:0] in_scale,
  input  logic       in_string_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_char_refused
);

  mftr_pkg::ctl_cmd_t   cmd;
  mftr_pkg::dp_status_t status;

  mftr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mftr_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_func          (in_func),
    .in_x             (in_x),
    .in_y             (in_y),
    .in_read_page     (in_read_page),
    .in_width         (in_width),
    .in_height        (in_height),
    .in_filled        (in_filled),
    .in_char_code     (in_char_code),
    .in_scale         (in_scale),
    .in_string_start  (in_string_start),
    .cmd              (cmd),
    .status           (status),
    .out_read_data    (out_read_data),
    .out_char_refused (out_char_refused)
  );

endmodule

// ----- hw/rtl/mftr_datapath.sv -----
// ----------------------------------------------------------------------------
// mftr_datapath
// Frame memory, text cursor, column/page walkers and column mask generation.
// ----------------------------------------------------------------------------
module mftr_datapath #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            in_func,
  input  logic [7:0]            in_x,
  input  logic [7:0]            in_y,
  input  logic [2:0]            in_read_page,
  input  logic [7:0]            in_width,
  input  logic [7:0]            in_height,
  input  logic                  in_filled,
  input  logic [7:0]            in_char_code,
  input  logic [2:0]            in_scale,
  input  logic                  in_string_start,
  input  mftr_pkg::ctl_cmd_t    cmd,
  output mftr_pkg::dp_status_t  status,
  output logic [7:0]            out_read_data,
  output logic                  out_char_refused
);

  localparam int NP    = (SCREEN_HEIGHT + 7) / 8;
  localparam int PW    = (NP > 1) ? $clog2(NP) : 1;
  localparam int DEPTH = SCREEN_WIDTH * NP;
  localparam int AW    = $clog2(DEPTH);
  localparam int PH    = NP * 8;
  localparam int EB    = mftr_pkg::EXP_BITS;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  logic [7:0]    cursor_r;
  logic          stopped_r;
  logic [1:0]    func_r;
  logic [7:0]    x_r, y_r, ybot_r, col_r, col_last_r;
  logic [2:0]    scale_r, gcol_r, sub_r;
  logic          filled_r, draw_r, refused_r, rd_ok_r;
  mftr_pkg::glyph_idx_t gidx_r;
  logic [PW-1:0] page_r;
  logic [PH-1:0] colmask_r;
  logic [AW-1:0] clr_r;

  // load-time decode
  logic [7:0] cur_eff, char_col_last, char_ybot, rect_col_last, rect_ybot;
  logic       stop_eff, edge_hit, refuse, y_in, x_in, char_draw, rect_ok, rd_ok;
  logic [8:0] adv9, ybot9, wc9, hc9, wlim9, hlim9;
  mftr_pkg::glyph_sel_t gsel;

  always_comb begin
    cur_eff  = in_string_start ? in_x : cursor_r;
    stop_eff = in_string_start ? 1'b0 : stopped_r;
    adv9     = 9'(in_scale) * 9'(mftr_pkg::CELL_ADVANCE);
    edge_hit = ({1'b0, cur_eff} + adv9) > 9'(SCREEN_WIDTH);
    refuse   = stop_eff || edge_hit;
    gsel     = mftr_pkg::glyph_index(in_char_code);
    y_in     = {1'b0, in_y} < 9'(SCREEN_HEIGHT);
    x_in     = {1'b0, in_x} < 9'(SCREEN_WIDTH);
    char_draw = !refuse && gsel.valid && (in_scale != 3'd0) && y_in;
    char_col_last = cur_eff + 8'(in_scale) * 8'(mftr_pkg::GLYPH_COLS) - 8'd1;
    ybot9 = {1'b0, in_y} + 9'(in_scale) * 9'(mftr_pkg::GLYPH_ROWS) - 9'd1;
    if (ybot9 > 9'(SCREEN_HEIGHT - 1)) ybot9 = 9'(SCREEN_HEIGHT - 1);
    char_ybot = ybot9[7:0];
    rect_ok = x_in && y_in && (in_width != 8'd0) && (in_height != 8'd0);
    wlim9   = 9'(SCREEN_WIDTH) - {1'b0, in_x};
    hlim9   = 9'(SCREEN_HEIGHT) - {1'b0, in_y};
    wc9     = ({1'b0, in_width} > wlim9) ? wlim9 : {1'b0, in_width};
    hc9     = ({1'b0, in_height} > hlim9) ? hlim9 : {1'b0, in_height};
    rect_col_last = 8'({1'b0, in_x} + wc9 - 9'd1);
    rect_ybot     = 8'({1'b0, in_y} + hc9 - 9'd1);
    rd_ok = x_in && (5'(in_read_page) < 5'(NP));
  end

  // glyph column expanded vertically by the scale
  mftr_pkg::glyph_byte_t gbyte;
  logic [EB-1:0] exp_c;
  logic [5:0]    lo, hi;

  always_comb begin
    gbyte = mftr_pkg::glyph_column(gidx_r, gcol_r);
    exp_c = '0;
    lo    = '0;
    hi    = '0;
    for (int e = 0; e < EB; e++) begin
      for (int r = 0; r < mftr_pkg::GLYPH_ROWS; r++) begin
        lo = 6'(r) * 6'(scale_r);
        hi = lo + 6'(scale_r);
        if (gbyte[r] && 6'(e) >= lo && 6'(e) < hi) exp_c[e] = 1'b1;
      end
    end
  end

  logic [PH-1:0] colmask_c;
  logic [8:0]    iv, d9;
  logic          in_cell, edge_col;

  always_comb begin
    colmask_c = '0;
    iv        = '0;
    d9        = '0;
    in_cell   = 1'b0;
    edge_col  = (col_r == x_r) || (col_r == col_last_r);
    for (int i = 0; i < PH; i++) begin
      iv      = 9'(i);
      d9      = iv - {1'b0, y_r};
      in_cell = (iv >= {1'b0, y_r}) && (iv <= {1'b0, ybot_r});
      if (func_r == mftr_pkg::FUNC_CHAR) begin
        colmask_c[i] = in_cell && exp_c[d9[5:0]];
      end else begin
        colmask_c[i] = in_cell && (filled_r || edge_col || iv == {1'b0, y_r} ||
                                   iv == {1'b0, ybot_r});
      end
    end
  end

  logic [AW-1:0] addr, mem_wa;
  logic [7:0]    mem_wd;
  logic          mem_we;

  assign addr   = AW'(page_r) * AW'(SCREEN_WIDTH) + AW'(col_r);
  assign mem_we = cmd.clr || cmd.wr;
  assign mem_wa = cmd.clr ? clr_r : addr;
  assign mem_wd = cmd.clr ? 8'd0 : (rdata_r | colmask_r[{page_r, 3'b000} +: 8]);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.rd) rdata_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r  <= '0;
      stopped_r <= 1'b0;
      clr_r     <= '0;
    end else begin
      if (cmd.clr) clr_r <= status.clr_end ? '0 : clr_r + 1'b1;
      if (cmd.load && in_func == mftr_pkg::FUNC_CHAR) begin
        cursor_r  <= refuse ? cur_eff : cur_eff + adv9[7:0];
        stopped_r <= refuse ? 1'b1 : stop_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r    <= in_func;
      x_r       <= in_x;
      y_r       <= in_y;
      scale_r   <= in_scale;
      filled_r  <= in_filled;
      gidx_r    <= gsel.idx;
      gcol_r    <= '0;
      sub_r     <= '0;
      refused_r <= 1'b0;
      rd_ok_r   <= 1'b0;
      draw_r    <= 1'b0;
      col_r     <= in_x;
      col_last_r <= rect_col_last;
      ybot_r    <= rect_ybot;
      page_r    <= PW'(in_read_page);
      case (in_func)
        mftr_pkg::FUNC_CHAR: begin
          x_r        <= cur_eff;
          col_r      <= cur_eff;
          col_last_r <= char_col_last;
          ybot_r     <= char_ybot;
          draw_r     <= char_draw;
          refused_r  <= refuse;
        end
        mftr_pkg::FUNC_RECT: draw_r <= rect_ok;
        mftr_pkg::FUNC_READ: rd_ok_r <= rd_ok;
        default: ;
      endcase
    end
    if (cmd.prep) begin
      colmask_r <= colmask_c;
      page_r    <= PW'(y_r[7:3]);
    end
    if (cmd.next_page) page_r <= page_r + 1'b1;
    if (cmd.next_col) begin
      col_r <= col_r + 8'd1;
      if (sub_r == scale_r - 3'd1) begin
        sub_r  <= '0;
        gcol_r <= gcol_r + 3'd1;
      end else begin
        sub_r <= sub_r + 3'd1;
      end
    end
    if (cmd.emit) begin
      out_read_data    <= (func_r == mftr_pkg::FUNC_READ && rd_ok_r) ? rdata_r : 8'd0;
      out_char_refused <= refused_r;
    end
  end

  always_comb begin
    status.func     = func_r;
    status.draw     = draw_r;
    status.rd_ok    = rd_ok_r;
    status.page_end = (page_r == PW'(ybot_r[7:3]));
    status.col_end  = (col_r == col_last_r);
    status.clr_end  = (clr_r == AW'(DEPTH - 1));
  end

endmodule

// ----- hw/rtl/mftr_ctrl.sv -----
// ----------------------------------------------------------------------------
// mftr_ctrl
// Sequencer: clearing pass, read-modify-write walk and result handoff.
// ----------------------------------------------------------------------------
module mftr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  mftr_pkg::dp_status_t status,
  output mftr_pkg::ctl_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_CLEAR  = 3'd2;
  localparam logic [2:0] S_PREP   = 3'd3;
  localparam logic [2:0] S_RD     = 3'd4;
  localparam logic [2:0] S_WR     = 3'd5;
  localparam logic [2:0] S_RRD    = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       op_r, op_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          op_nxt    = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status.func == mftr_pkg::FUNC_CLEAR) begin
          state_nxt = S_CLEAR;
        end else if (status.func == mftr_pkg::FUNC_READ) begin
          state_nxt = status.rd_ok ? S_RRD : S_DONE;
        end else begin
          state_nxt = status.draw ? S_PREP : S_DONE;
        end
      end
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (status.clr_end) state_nxt = op_r ? S_DONE : S_IDLE;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.wr = 1'b1;
        if (!status.page_end) begin
          cmd.next_page = 1'b1;
          state_nxt     = S_RD;
        end else if (!status.col_end) begin
          cmd.next_col = 1'b1;
          state_nxt    = S_PREP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.emit  = 1'b1;
          op_nxt    = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      op_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("result not presented after emit");

  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> $past(cmd.rd))
    else $error("write without preceding read");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && out_stall) |=> state_r == S_DONE)
    else $error("result overwrote a pending word");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !op_r)
    else $error("new item accepted during an operation");

endmodule

// ----- test/mono_framebuffer_text_rect_draw_tb.sv -----
// ----------------------------------------------------------------------------
// mono_framebuffer_text_rect_draw_tb
// Drives clear, character, rectangle and read words into the frame store
// engine, keeps a shadow copy of the store and the text cursor, and compares
// every result word against the shadow's prediction.
// ----------------------------------------------------------------------------
module mono_framebuffer_text_rect_draw_tb;

  localparam int SCR_W     = 128;
  localparam int SCR_H     = 64;
  localparam int PAGES     = (SCR_H + 7) / 8;
  localparam int CYCLE_CAP = 2000000;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] x;
    logic [7:0] y;
    logic [2:0] page;
    logic [7:0] w;
    logic [7:0] h;
    logic       filled;
    logic [7:0] code;
    logic [2:0] scale;
    logic       start;
  } op_word_t;

  typedef struct packed {
    logic [7:0] rd;
    logic       refused;
  } res_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_func = '0;
  logic [7:0] in_x = '0, in_y = '0, in_width = '0, in_height = '0, in_char_code = '0;
  logic [2:0] in_read_page = '0, in_scale = '0;
  logic in_filled = 1'b0, in_string_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_read_data;
  logic out_char_refused;

  logic [7:0] shadow_fb [SCR_W*PAGES];
  logic [7:0] cursor;
  logic       stopped;
  res_word_t  expected_q [$];
  int mismatches = 0;
  int cycles = 0;
  int hold_cycles = 0;
  int rx_wait = 0;

  mono_framebuffer_text_rect_draw u_top (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int glyph_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "Z") return c - "A" + 10;
    case (c)
      "<": return 36;
      "+": return 37;
      "*": return 38;
      ">": return 39;
      ".": return 40;
      "-": return 41;
      "%": return 42;
      default: return -1;
    endcase
  endfunction

  task automatic plot(int px, int py);
    if (px < SCR_W && py < SCR_H) shadow_fb[(py/8)*SCR_W+px][py%8] = 1'b1;
  endtask

  task automatic predict_word(op_word_t op);
    res_word_t r;
    int g, cur, w, h;
    r = '0;
    case (op.func)
      mftr_pkg::FUNC_CLEAR: foreach (shadow_fb[i]) shadow_fb[i] = '0;
      mftr_pkg::FUNC_CHAR: begin
        if (op.start) begin
          cursor = op.x;
          stopped = 1'b0;
        end
        if (stopped) r.refused = 1'b1;
        else begin
          cur = cursor;
          if (cur + mftr_pkg::CELL_ADVANCE*op.scale > SCR_W) begin
            stopped = 1'b1;
            r.refused = 1'b1;
          end else begin
            g = glyph_of(op.code);
            if (g >= 0)
              for (int c = 0; c < mftr_pkg::GLYPH_COLS; c++)
                for (int rw = 0; rw < mftr_pkg::GLYPH_ROWS; rw++)
                  if (mftr_pkg::GLYPH_ROM[g][c][rw])
                    for (int dx = 0; dx < op.scale; dx++)
                      for (int dy = 0; dy < op.scale; dy++)
                        plot(cur + c*op.scale + dx, op.y + rw*op.scale + dy);
            cursor = 8'(cur + mftr_pkg::CELL_ADVANCE*op.scale);
          end
        end
      end
      mftr_pkg::FUNC_RECT: begin
        if (op.x < SCR_W && op.y < SCR_H && op.w != 0 && op.h != 0) begin
          w = (op.w > SCR_W - op.x) ? SCR_W - op.x : op.w;
          h = (op.h > SCR_H - op.y) ? SCR_H - op.y : op.h;
          for (int dy = 0; dy < h; dy++)
            for (int dx = 0; dx < w; dx++)
              if (op.filled || dx == 0 || dy == 0 || dx == w-1 || dy == h-1)
                plot(op.x + dx, op.y + dy);
        end
      end
      mftr_pkg::FUNC_READ:
        if (op.x < SCR_W && op.page < PAGES) r.rd = shadow_fb[op.page*SCR_W + op.x];
    endcase
    expected_q.push_back(r);
  endtask

  // sample results and compare with the oldest prediction
  always @(posedge clk) begin
    res_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word rd=%h ref=%b",
                                       out_read_data, out_char_refused);
      end else begin
        e = expected_q.pop_front();
        if (e.rd !== out_read_data || e.refused !== out_char_refused) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp rd=%h ref=%b got rd=%h ref=%b",
                     e.rd, e.refused, out_read_data, out_char_refused);
        end
      end
    end
  end

  // receiver stall: count down hold_cycles, else a random rx_wait drawn per taken word
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait <= rx_wait - 1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid && !out_stall) rx_wait <= $urandom_range(0, 16);
    end
  end

  bit no_gaps = 1'b0;

  task automatic send_word(op_word_t op);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 1)) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    {in_func, in_x, in_y, in_read_page, in_width, in_height, in_filled,
     in_char_code, in_scale, in_string_start} <= op;
    predict_word(op);
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic op_word_t rand_word();
    op_word_t op;
    op = op_word_t'($bits(op_word_t)'({$urandom, $urandom}));
    return op;
  endfunction

  function automatic op_word_t char_word(logic [7:0] c, logic [7:0] x, logic [7:0] y,
                                         logic [2:0] s, logic st);
    op_word_t op;
    op = rand_word();
    op.func = mftr_pkg::FUNC_CHAR; op.code = c; op.x = x; op.y = y; op.scale = s;
    op.start = st;
    return op;
  endfunction

  function automatic op_word_t rect_word(logic [7:0] x, logic [7:0] y, logic [7:0] w,
                                         logic [7:0] h, logic f);
    op_word_t op;
    op = rand_word();
    op.func = mftr_pkg::FUNC_RECT; op.x = x; op.y = y; op.w = w; op.h = h; op.filled = f;
    return op;
  endfunction

  function automatic op_word_t read_word(logic [7:0] x, logic [2:0] p);
    op_word_t op;
    op = rand_word();
    op.func = mftr_pkg::FUNC_READ; op.x = x; op.page = p;
    return op;
  endfunction

  function automatic op_word_t clear_word();
    op_word_t op;
    op = rand_word();
    op.func = mftr_pkg::FUNC_CLEAR;
    return op;
  endfunction

  task automatic test_directed();
    send_word(read_word(8'd0, 3'd0));
    send_word(char_word("A", 8'd0, 8'd0, 3'd1, 1'b1));
    send_word(char_word("%", 8'd0, 8'd0, 3'd2, 1'b0));
    send_word(char_word(8'd0, 8'd0, 8'd0, 3'd1, 1'b0));    // blank still advances
    send_word(char_word("Z", 8'd0, 8'd60, 3'd0, 1'b0));    // zero scale
    send_word(char_word("9", 8'd120, 8'd3, 3'd7, 1'b1));   // passes right edge
    send_word(char_word("0", 8'd0, 8'd0, 3'd1, 1'b0));     // refused while stopped
    send_word(char_word("<", 8'd122, 8'd59, 3'd1, 1'b1));  // fits exactly, clipped low
    send_word(char_word(">", 8'd255, 8'd255, 3'd0, 1'b1)); // cursor past edge
    send_word(rect_word(8'd10, 8'd10, 8'd255, 8'd255, 1'b0));
    send_word(rect_word(8'd0, 8'd0, 8'd1, 8'd1, 1'b1));
    send_word(rect_word(8'd128, 8'd0, 8'd5, 8'd5, 1'b1));
    send_word(rect_word(8'd0, 8'd64, 8'd5, 8'd5, 1'b1));
    send_word(rect_word(8'd5, 8'd5, 8'd0, 8'd5, 1'b1));
    send_word(rect_word(8'd127, 8'd63, 8'd255, 8'd255, 1'b1));
    for (int i = 0; i < 5; i++) send_word(read_word(8'(i*31), 3'(i+3)));
    send_word(read_word(8'd200, 3'd1));
    send_word(clear_word());
    send_word(read_word(8'd10, 3'd1));
  endtask

  task automatic test_random(int n);
    op_word_t op;
    for (int i = 0; i < n; i++) begin
      op = rand_word();
      case ($urandom_range(0, 19))
        0: op.func = mftr_pkg::FUNC_CLEAR;
        1, 2, 3, 4, 5, 6, 7, 8: begin
          op.func = mftr_pkg::FUNC_CHAR;
          op.scale = ($urandom_range(0, 9) == 0) ? op.scale : 3'($urandom_range(1, 2));
          if ($urandom_range(0, 3) != 0) op.code = 8'($urandom_range(8'h25, 8'h5A));
          op.start = ($urandom_range(0, 5) == 0);
          if (op.start && $urandom_range(0, 2) != 0) op.x = 8'($urandom_range(0, 127));
          if ($urandom_range(0, 2) != 0) op.y = 8'($urandom_range(0, 63));
        end
        9, 10, 11: begin
          op.func = mftr_pkg::FUNC_RECT;
          if ($urandom_range(0, 3) != 0) begin
            op.x = 8'($urandom_range(0, 130));
            op.y = 8'($urandom_range(0, 66));
            op.w = 8'($urandom_range(0, 24));
            op.h = 8'($urandom_range(0, 20));
          end
        end
        default: begin
          op.func = mftr_pkg::FUNC_READ;
          if ($urandom_range(0, 4) != 0) op.x = 8'($urandom_range(0, 127));
        end
      endcase
      send_word(op);
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    no_gaps = 1'b1;
    for (int i = 0; i < 12; i++) send_word(read_word(8'($urandom_range(0, 127)), 3'(i)));
    no_gaps = 1'b0;
  endtask

  initial begin
    foreach (shadow_fb[i]) shadow_fb[i] = '0;
    cursor = '0;
    stopped = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(650);
    test_backpressure();
    test_random(720);
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (50) @(negedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
